// ===== hdl/hsvtl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvtl_pkg
// Shared widths, codes and types of the HSV traffic light classifier.
// ----------------------------------------------------------------------------
package hsvtl_pkg;

   localparam int CountWidth  = 20;  // per-color hit counter, 8..32
   localparam int TotalWidth  = 20;  // reported totals
   localparam int ThreshWidth = 20;
   localparam int BoxWidth    = 48;
   localparam int CmpWidth    = (CountWidth > TotalWidth) ? CountWidth : TotalWidth;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 48;

   // queue between classifier and accumulator, power of two
   localparam int FifoDepth      = 4;
   localparam int FifoIndexWidth = $clog2(FifoDepth);
   localparam int LevelWidth     = $clog2(FifoDepth + 1);

   localparam logic [CmpWidth-1:0] TotalMaxCmp =
      CmpWidth'((64'd1 << TotalWidth) - 64'd1);

   // register map
   localparam logic [CsrIndexWidth-1:0] CSR_RED_BOX      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_YELLOW_BOX   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_GREEN_BOX    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_DOMINANT_MIN = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_MINOR_MAX    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_GREEN_MIN    = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_ARROW_MAX    = 3'd6;

   localparam logic [ThreshWidth-1:0] DominantMinReset = 20'd50;
   localparam logic [ThreshWidth-1:0] MinorMaxReset    = 20'd10;
   localparam logic [ThreshWidth-1:0] GreenMinReset    = 20'd10;
   localparam logic [ThreshWidth-1:0] ArrowMaxReset    = 20'd70;

   // light codes
   localparam logic [1:0] LIGHT_RED    = 2'd0;
   localparam logic [1:0] LIGHT_YELLOW = 2'd1;
   localparam logic [1:0] LIGHT_ARROW  = 2'd2;
   localparam logic [1:0] LIGHT_GREEN  = 2'd3;

   typedef struct packed {
      logic red;
      logic yellow;
      logic green;
      logic last;
   } hit_type;

   typedef struct packed {
      logic [ThreshWidth-1:0] dominant_min;
      logic [ThreshWidth-1:0] minor_max;
      logic [ThreshWidth-1:0] green_min;
      logic [ThreshWidth-1:0] arrow_max;
   } thresh_type;

   typedef struct packed {
      logic                  not_empty;
      logic                  not_full;
      logic [LevelWidth-1:0] level;
   } fifo_status_type;

   typedef struct packed {
      logic pop;
      logic frame_done;
   } back_status_type;

endpackage
`default_nettype wire

// ===== hdl/hsvtl_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvtl_front
// Tests each incoming pixel against the three color boxes.
// ----------------------------------------------------------------------------
module hsvtl_front (
   input  wire logic                            req_valid,
   input  wire logic [7:0]                      req_hue,
   input  wire logic [7:0]                      req_saturation,
   input  wire logic [7:0]                      req_brightness,
   input  wire logic                            req_frame_end,
   input  wire logic [hsvtl_pkg::BoxWidth-1:0]  red_box,
   input  wire logic [hsvtl_pkg::BoxWidth-1:0]  yellow_box,
   input  wire logic [hsvtl_pkg::BoxWidth-1:0]  green_box,
   output logic                                 push,
   output hsvtl_pkg::hit_type                   push_data
);

   // bounds inclusive; low above high matches nothing
   function automatic logic in_box(input logic [7:0] h, input logic [7:0] s,
                                   input logic [7:0] v,
                                   input logic [hsvtl_pkg::BoxWidth-1:0] box);
      logic hit_h;
      logic hit_s;
      logic hit_v;
      hit_h = (h >= box[7:0])   && (h <= box[15:8]);
      hit_s = (s >= box[23:16]) && (s <= box[31:24]);
      hit_v = (v >= box[39:32]) && (v <= box[47:40]);
      return hit_h && hit_s && hit_v;
   endfunction

   assign push = req_valid;

   always_comb begin
      push_data.red    = in_box(req_hue, req_saturation, req_brightness, red_box);
      push_data.yellow = in_box(req_hue, req_saturation, req_brightness, yellow_box);
      push_data.green  = in_box(req_hue, req_saturation, req_brightness, green_box);
      push_data.last   = req_frame_end;
   end

endmodule
`default_nettype wire

// ===== hdl/hsvtl_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvtl_fifo
// Short queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module hsvtl_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire hsvtl_pkg::hit_type        push_data,
   input  wire logic                      pop,
   output hsvtl_pkg::hit_type             head,
   output hsvtl_pkg::fifo_status_type     status
);

   hsvtl_pkg::hit_type mem [hsvtl_pkg::FifoDepth];

   logic [hsvtl_pkg::FifoIndexWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [hsvtl_pkg::FifoIndexWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [hsvtl_pkg::LevelWidth-1:0]     level_ff, level_in;
   logic                                 do_push;
   logic                                 do_pop;

   always_comb begin
      status.level     = level_ff;
      status.not_empty = (level_ff != '0);
      status.not_full  = (level_ff != hsvtl_pkg::LevelWidth'(hsvtl_pkg::FifoDepth));
   end

   assign do_push = push && status.not_full;
   assign do_pop  = pop && status.not_empty;
   assign head    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + hsvtl_pkg::FifoIndexWidth'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + hsvtl_pkg::FifoIndexWidth'(1) : rd_ptr_ff;
      level_in  = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + hsvtl_pkg::LevelWidth'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - hsvtl_pkg::LevelWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/hsvtl_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvtl_back
// Counts hits per color, decides the light at frame end, holds the result.
// ----------------------------------------------------------------------------
module hsvtl_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire hsvtl_pkg::hit_type                  head,
   input  wire logic                                head_valid,
   input  wire hsvtl_pkg::thresh_type               thresh,
   output hsvtl_pkg::back_status_type               status,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_light,
   output logic [hsvtl_pkg::TotalWidth-1:0]         rsp_red_total,
   output logic [hsvtl_pkg::TotalWidth-1:0]         rsp_yellow_total,
   output logic [hsvtl_pkg::TotalWidth-1:0]         rsp_green_total
);

   localparam int CW = hsvtl_pkg::CountWidth;
   localparam int MW = hsvtl_pkg::CmpWidth;
   localparam int TW = hsvtl_pkg::TotalWidth;

   logic [CW-1:0] red_ff, red_in, yel_ff, yel_in, grn_ff, grn_in;
   logic [CW-1:0] red_nx, yel_nx, grn_nx;
   logic [MW-1:0] r_c, y_c, g_c, dom_c, minor_c, gmin_c, arrow_c;
   logic          valid_ff, valid_in;
   logic [1:0]    light_ff, light_in;
   logic [TW-1:0] red_tot_ff, yel_tot_ff, grn_tot_ff;
   logic          out_free;
   logic          pop;
   logic          frame_done;

   function automatic logic [TW-1:0] report(input logic [MW-1:0] c);
      return (c > hsvtl_pkg::TotalMaxCmp) ? TW'(hsvtl_pkg::TotalMaxCmp) : TW'(c);
   endfunction

   assign out_free   = !valid_ff || rsp_ready;
   assign pop        = head_valid && (!head.last || out_free);
   assign frame_done = pop && head.last;

   always_comb begin
      status.pop        = pop;
      status.frame_done = frame_done;
   end

   // saturating bumps
   always_comb begin
      red_nx = (head.red    && red_ff != '1) ? red_ff + CW'(1) : red_ff;
      yel_nx = (head.yellow && yel_ff != '1) ? yel_ff + CW'(1) : yel_ff;
      grn_nx = (head.green  && grn_ff != '1) ? grn_ff + CW'(1) : grn_ff;
   end

   always_comb begin
      r_c     = MW'(red_nx);
      y_c     = MW'(yel_nx);
      g_c     = MW'(grn_nx);
      dom_c   = MW'(thresh.dominant_min);
      minor_c = MW'(thresh.minor_max);
      gmin_c  = MW'(thresh.green_min);
      arrow_c = MW'(thresh.arrow_max);
      light_in = hsvtl_pkg::LIGHT_RED;
      if (r_c > dom_c && y_c < minor_c && g_c < minor_c) begin
         light_in = hsvtl_pkg::LIGHT_RED;
      end else if (y_c > dom_c && r_c < minor_c && g_c < minor_c) begin
         light_in = hsvtl_pkg::LIGHT_YELLOW;
      end else if (g_c > gmin_c && r_c < minor_c && y_c < minor_c) begin
         light_in = (g_c < arrow_c) ? hsvtl_pkg::LIGHT_ARROW : hsvtl_pkg::LIGHT_GREEN;
      end
   end

   always_comb begin
      red_in = red_ff;
      yel_in = yel_ff;
      grn_in = grn_ff;
      if (frame_done) begin
         red_in = '0;
         yel_in = '0;
         grn_in = '0;
      end else if (pop) begin
         red_in = red_nx;
         yel_in = yel_nx;
         grn_in = grn_nx;
      end
      valid_in = frame_done ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff   <= '0;
         yel_ff   <= '0;
         grn_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         red_ff   <= red_in;
         yel_ff   <= yel_in;
         grn_ff   <= grn_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         light_ff   <= light_in;
         red_tot_ff <= report(r_c);
         yel_tot_ff <= report(y_c);
         grn_tot_ff <= report(g_c);
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_light        = light_ff;
   assign rsp_red_total    = red_tot_ff;
   assign rsp_yellow_total = yel_tot_ff;
   assign rsp_green_total  = grn_tot_ff;

endmodule
`default_nettype wire

// ===== hdl/hsv_traffic_light_classifier_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_traffic_light_classifier_core
// Counts HSV pixels inside three color boxes and reports the light per frame.
// ----------------------------------------------------------------------------
//
//  channel | ports      | direction | moves
//  --------+------------+-----------+-----------------------------------------
//  req     | req_*      | in        | one pixel per transaction, frame_end flag
//  rsp     | rsp_*      | out       | light and three totals, once per frame
//  csr     | csr_*      | in        | register write (index, data), always ready
//
//  One pixel per cycle sustained while rsp is not stalled: the box compares
//  feed a 4-entry queue, and the accumulator drains one entry per cycle
//  (counter bump plus threshold compare). With the queue empty, a frame_end
//  entry passes the queue and then the valid register before rsp_valid rises.
//  Reset (synchronous) clears counters, queue and result valid, and loads the
//  register reset values. A stalled rsp holds the frame_end entry at the queue
//  head; pixels keep entering until the queue is full, then req_ready drops.
//
module hsv_traffic_light_classifier_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // pixel input
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [7:0]                           req_hue,
   input  wire logic [7:0]                           req_saturation,
   input  wire logic [7:0]                           req_brightness,
   input  wire logic                                 req_frame_end,
   // frame result
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [1:0]                                rsp_light,
   output logic [hsvtl_pkg::TotalWidth-1:0]          rsp_red_total,
   output logic [hsvtl_pkg::TotalWidth-1:0]          rsp_yellow_total,
   output logic [hsvtl_pkg::TotalWidth-1:0]          rsp_green_total,
   // register writes
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [hsvtl_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [hsvtl_pkg::CsrDataWidth-1:0]   csr_wdata
);

   localparam int BW = hsvtl_pkg::BoxWidth;
   localparam int HW = hsvtl_pkg::ThreshWidth;

   logic [BW-1:0]                red_box_ff, yellow_box_ff, green_box_ff;
   hsvtl_pkg::thresh_type        thresh_ff;
   logic                         csr_write;

   logic                         push;
   hsvtl_pkg::hit_type           push_data;
   hsvtl_pkg::hit_type           head;
   hsvtl_pkg::fifo_status_type   fifo_status;
   hsvtl_pkg::back_status_type   back_status;

   // ---------------- register file ----------------
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_box_ff             <= '0;
         yellow_box_ff          <= '0;
         green_box_ff           <= '0;
         thresh_ff.dominant_min <= hsvtl_pkg::DominantMinReset;
         thresh_ff.minor_max    <= hsvtl_pkg::MinorMaxReset;
         thresh_ff.green_min    <= hsvtl_pkg::GreenMinReset;
         thresh_ff.arrow_max    <= hsvtl_pkg::ArrowMaxReset;
      end else if (csr_write) begin
         case (csr_index)
            hsvtl_pkg::CSR_RED_BOX:      red_box_ff             <= csr_wdata[BW-1:0];
            hsvtl_pkg::CSR_YELLOW_BOX:   yellow_box_ff          <= csr_wdata[BW-1:0];
            hsvtl_pkg::CSR_GREEN_BOX:    green_box_ff           <= csr_wdata[BW-1:0];
            hsvtl_pkg::CSR_DOMINANT_MIN: thresh_ff.dominant_min <= csr_wdata[HW-1:0];
            hsvtl_pkg::CSR_MINOR_MAX:    thresh_ff.minor_max    <= csr_wdata[HW-1:0];
            hsvtl_pkg::CSR_GREEN_MIN:    thresh_ff.green_min    <= csr_wdata[HW-1:0];
            hsvtl_pkg::CSR_ARROW_MAX:    thresh_ff.arrow_max    <= csr_wdata[HW-1:0];
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   // ---------------- front: classify ----------------
   hsvtl_front u_front (
      .req_valid      (req_valid),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .req_frame_end  (req_frame_end),
      .red_box        (red_box_ff),
      .yellow_box     (yellow_box_ff),
      .green_box      (green_box_ff),
      .push           (push),
      .push_data      (push_data)
   );

   assign req_ready = fifo_status.not_full;

   // ---------------- queue ----------------
   hsvtl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (back_status.pop),
      .head      (head),
      .status    (fifo_status)
   );

   // ---------------- back: count and decide ----------------
   hsvtl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_valid       (fifo_status.not_empty),
      .thresh           (thresh_ff),
      .status           (back_status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_light        (rsp_light),
      .rsp_red_total    (rsp_red_total),
      .rsp_yellow_total (rsp_yellow_total),
      .rsp_green_total  (rsp_green_total)
   );

   // ---------------- assertions ----------------
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.level <= hsvtl_pkg::LevelWidth'(hsvtl_pkg::FifoDepth))
      else $error("queue level above depth");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(back_status.frame_done))
      else $error("result valid without a frame end");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      back_status.frame_done |-> (!rsp_valid || rsp_ready))
      else $error("pending result overwritten");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      back_status.pop |-> fifo_status.not_empty)
      else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HSV traffic light classifier core. Pixels are
// driven from a queue; each accepted pixel is run through a local predictor of
// the color boxes, the saturating hit counters and the per-frame light
// decision. Frame results are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;

   // Color slots of the predictor; order matches the box registers.
   localparam int ColorRed    = 0;
   localparam int ColorYellow = 1;
   localparam int ColorGreen  = 2;
   localparam int ColorNone   = 3;   // frame of unbiased pixels

   // Index past the register map; writes there must change nothing.
   localparam logic [hsvtl_pkg::CsrIndexWidth-1:0] CSR_UNUSED = 3'd7;

   // Queue depth 4 plus the result register, with margin.
   localparam int DrainCycles = 16;
   // Pending pixels held ahead of the driver.
   localparam int BacklogMax  = 256;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
      logic       frame_end;
   } pixel_type;

   typedef struct packed {
      logic [1:0]                       light;
      logic [hsvtl_pkg::TotalWidth-1:0] red_total;
      logic [hsvtl_pkg::TotalWidth-1:0] yellow_total;
      logic [hsvtl_pkg::TotalWidth-1:0] green_total;
   } frame_result_type;

   // ------------------------------------------------------------------------
   // DUT ports; every input has a known value from time zero.
   // ------------------------------------------------------------------------
   logic                                clock            = 1'b0;
   logic                                reset            = 1'b1;
   logic                                req_valid        = 1'b0;
   logic                                req_ready;
   logic [7:0]                          req_hue          = '0;
   logic [7:0]                          req_saturation   = '0;
   logic [7:0]                          req_brightness   = '0;
   logic                                req_frame_end    = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready        = 1'b0;
   logic [1:0]                          rsp_light;
   logic [hsvtl_pkg::TotalWidth-1:0]    rsp_red_total;
   logic [hsvtl_pkg::TotalWidth-1:0]    rsp_yellow_total;
   logic [hsvtl_pkg::TotalWidth-1:0]    rsp_green_total;
   logic                                csr_valid        = 1'b0;
   logic                                csr_ready;
   logic [hsvtl_pkg::CsrIndexWidth-1:0] csr_index        = '0;
   logic [hsvtl_pkg::CsrDataWidth-1:0]  csr_wdata        = '0;

   hsv_traffic_light_classifier_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_hue          (req_hue),
      .req_saturation   (req_saturation),
      .req_brightness   (req_brightness),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_light        (rsp_light),
      .rsp_red_total    (rsp_red_total),
      .rsp_yellow_total (rsp_yellow_total),
      .rsp_green_total  (rsp_green_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Shared bench state
   // ------------------------------------------------------------------------
   pixel_type          pixel_queue [$];        // pixels waiting for the driver
   frame_result_type   frame_results_due [$];  // predicted frame results, oldest first
   int                 pixels_queued = 0;
   int                 pixels_taken  = 0;
   int                 idle_odds     = 0;      // 1 in N chance of an idle burst, 0 = none
   int                 input_hold    = 0;
   int                 output_hold   = 0;
   bit                 mismatch_seen = 1'b0;
   pixel_type          next_pixel;
   frame_result_type   arrived;

   // Register shadow, updated on each accepted csr transaction.
   logic [hsvtl_pkg::BoxWidth-1:0]   box_cfg [3];
   hsvtl_pkg::thresh_type            limits_cfg;
   // Boxes as last programmed; the stimulus aims pixels into them.
   logic [hsvtl_pkg::BoxWidth-1:0]   box_plan [3];
   // Per-color hit counters of the frame in progress.
   logic [hsvtl_pkg::CountWidth-1:0] hit_count [3];

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   // Bounds are inclusive; low above high leaves the box empty.
   function automatic bit in_box(pixel_type px, logic [hsvtl_pkg::BoxWidth-1:0] box);
      return px.hue        >= box[7:0]   && px.hue        <= box[15:8]  &&
             px.saturation >= box[23:16] && px.saturation <= box[31:24] &&
             px.brightness >= box[39:32] && px.brightness <= box[47:40];
   endfunction

   function automatic logic [hsvtl_pkg::TotalWidth-1:0] report_total(
         logic [hsvtl_pkg::CountWidth-1:0] cnt);
      return (hsvtl_pkg::CmpWidth'(cnt) > hsvtl_pkg::TotalMaxCmp)
             ? hsvtl_pkg::TotalMaxCmp[hsvtl_pkg::TotalWidth-1:0]
             : hsvtl_pkg::TotalWidth'(cnt);
   endfunction

   // Counts one accepted pixel; on frame_end it forms the expected result and
   // clears the counters. Boxes may overlap, so one pixel can hit several.
   function automatic void count_pixel(pixel_type px);
      logic [hsvtl_pkg::CountWidth-1:0] r, y, g;
      frame_result_type                 res;
      for (int c = ColorRed; c <= ColorGreen; c++)
         if (in_box(px, box_cfg[c]) && hit_count[c] != '1)
            hit_count[c] = hit_count[c] + 1'b1;
      if (!px.frame_end)
         return;
      r = hit_count[ColorRed];
      y = hit_count[ColorYellow];
      g = hit_count[ColorGreen];
      // red is also the fallback when no color wins
      res.light = hsvtl_pkg::LIGHT_RED;
      if (r > limits_cfg.dominant_min && y < limits_cfg.minor_max &&
          g < limits_cfg.minor_max)
         res.light = hsvtl_pkg::LIGHT_RED;
      else if (y > limits_cfg.dominant_min && r < limits_cfg.minor_max &&
               g < limits_cfg.minor_max)
         res.light = hsvtl_pkg::LIGHT_YELLOW;
      else if (g > limits_cfg.green_min && r < limits_cfg.minor_max &&
               y < limits_cfg.minor_max)
         res.light = (g < limits_cfg.arrow_max) ? hsvtl_pkg::LIGHT_ARROW
                                                : hsvtl_pkg::LIGHT_GREEN;
      res.red_total    = report_total(r);
      res.yellow_total = report_total(y);
      res.green_total  = report_total(g);
      frame_results_due.push_back(res);
      for (int c = ColorRed; c <= ColorGreen; c++)
         hit_count[c] = '0;
   endfunction

   // Shadow registers; out-of-range indexes fall through untouched.
   always @(posedge clock) begin
      if (reset) begin
         for (int c = ColorRed; c <= ColorGreen; c++)
            box_cfg[c] <= '0;
         limits_cfg.dominant_min <= hsvtl_pkg::DominantMinReset;
         limits_cfg.minor_max    <= hsvtl_pkg::MinorMaxReset;
         limits_cfg.green_min    <= hsvtl_pkg::GreenMinReset;
         limits_cfg.arrow_max    <= hsvtl_pkg::ArrowMaxReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hsvtl_pkg::CSR_RED_BOX:      box_cfg[ColorRed]    <= csr_wdata;
            hsvtl_pkg::CSR_YELLOW_BOX:   box_cfg[ColorYellow] <= csr_wdata;
            hsvtl_pkg::CSR_GREEN_BOX:    box_cfg[ColorGreen]  <= csr_wdata;
            hsvtl_pkg::CSR_DOMINANT_MIN:
               limits_cfg.dominant_min <= csr_wdata[hsvtl_pkg::ThreshWidth-1:0];
            hsvtl_pkg::CSR_MINOR_MAX:
               limits_cfg.minor_max    <= csr_wdata[hsvtl_pkg::ThreshWidth-1:0];
            hsvtl_pkg::CSR_GREEN_MIN:
               limits_cfg.green_min    <= csr_wdata[hsvtl_pkg::ThreshWidth-1:0];
            hsvtl_pkg::CSR_ARROW_MAX:
               limits_cfg.arrow_max    <= csr_wdata[hsvtl_pkg::ThreshWidth-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pixel driver: predicts on acceptance, then loads the next pixel, an idle
   // cycle, or nothing. Valid is only touched once the slot is free, so a
   // stalled pixel stays put with its payload.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         input_hold = 0;
         for (int c = ColorRed; c <= ColorGreen; c++)
            hit_count[c] = '0;
      end else begin
         if (req_valid && req_ready) begin
            count_pixel({req_hue, req_saturation, req_brightness, req_frame_end});
            pixels_taken++;
         end
         if (!req_valid || req_ready) begin
            if (input_hold > 0) begin
               input_hold--;
               req_valid <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
               // idle burst, this one included; its remaining length goes to input_hold
               input_hold = $urandom_range(10, 0);
               req_valid  <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
               next_pixel     = pixel_queue.pop_front();
               req_valid      <= 1'b1;
               req_hue        <= next_pixel.hue;
               req_saturation <= next_pixel.saturation;
               req_brightness <= next_pixel.brightness;
               req_frame_end  <= next_pixel.frame_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: checks each accepted transaction against the oldest
   // prediction and throws in random back-pressure bursts.
   // ------------------------------------------------------------------------
   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_seen = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         output_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_results_due.size() == 0) begin
               $display("%0t ns: frame result with none expected, expected none, actual %0d",
                        $time, rsp_light);
               mismatch_seen = 1'b1;
            end else begin
               arrived = frame_results_due.pop_front();
               check_field("light",        32'(arrived.light),        32'(rsp_light));
               check_field("red_total",    32'(arrived.red_total),    32'(rsp_red_total));
               check_field("yellow_total", 32'(arrived.yellow_total), 32'(rsp_yellow_total));
               check_field("green_total",  32'(arrived.green_total),  32'(rsp_green_total));
            end
         end
         if (output_hold > 0) begin
            output_hold--;
            rsp_ready <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
            output_hold = $urandom_range(10, 0);
            rsp_ready   <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic send_pixel(input logic [7:0] h, input logic [7:0] s,
                             input logic [7:0] v, input logic last);
      while (pixel_queue.size() >= BacklogMax)
         @(posedge clock);
      pixel_queue.push_back({h, s, v, last});
      pixels_queued++;
   endtask

   task automatic write_reg(input logic [hsvtl_pkg::CsrIndexWidth-1:0] idx,
                            input logic [hsvtl_pkg::CsrDataWidth-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits until every pixel is taken and every frame result is back, then
   // lets the pipeline settle.
   task automatic wait_idle();
      while (pixels_taken != pixels_queued || frame_results_due.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic [hsvtl_pkg::BoxWidth-1:0] pack_box(
         input logic [7:0] h_lo, input logic [7:0] h_hi,
         input logic [7:0] s_lo, input logic [7:0] s_hi,
         input logic [7:0] v_lo, input logic [7:0] v_hi);
      return {v_hi, v_lo, s_hi, s_lo, h_hi, h_lo};
   endfunction

   function automatic hsvtl_pkg::thresh_type limits(
         input logic [hsvtl_pkg::ThreshWidth-1:0] dom,
         input logic [hsvtl_pkg::ThreshWidth-1:0] minor,
         input logic [hsvtl_pkg::ThreshWidth-1:0] gmin,
         input logic [hsvtl_pkg::ThreshWidth-1:0] arrow);
      hsvtl_pkg::thresh_type lim;
      lim.dominant_min = dom;
      lim.minor_max    = minor;
      lim.green_min    = gmin;
      lim.arrow_max    = arrow;
      return lim;
   endfunction

   // Writes every register. Threshold writes carry junk above bit 19, and a
   // junk write to the unused index goes along each time.
   task automatic apply_settings(input logic [hsvtl_pkg::BoxWidth-1:0] red_box,
                                 input logic [hsvtl_pkg::BoxWidth-1:0] yellow_box,
                                 input logic [hsvtl_pkg::BoxWidth-1:0] green_box,
                                 input hsvtl_pkg::thresh_type lim);
      box_plan[ColorRed]    = red_box;
      box_plan[ColorYellow] = yellow_box;
      box_plan[ColorGreen]  = green_box;
      write_reg(hsvtl_pkg::CSR_RED_BOX,      red_box);
      write_reg(hsvtl_pkg::CSR_YELLOW_BOX,   yellow_box);
      write_reg(hsvtl_pkg::CSR_GREEN_BOX,    green_box);
      write_reg(hsvtl_pkg::CSR_DOMINANT_MIN, {28'($urandom), lim.dominant_min});
      write_reg(hsvtl_pkg::CSR_MINOR_MAX,    {28'($urandom), lim.minor_max});
      write_reg(hsvtl_pkg::CSR_GREEN_MIN,    {28'($urandom), lim.green_min});
      write_reg(hsvtl_pkg::CSR_ARROW_MAX,    {28'($urandom), lim.arrow_max});
      write_reg(CSR_UNUSED,                  48'({$urandom, $urandom}));
   endtask

   // Mostly a normal box; sometimes full, empty, or raw random bits.
   function automatic logic [hsvtl_pkg::BoxWidth-1:0] random_box();
      logic [hsvtl_pkg::BoxWidth-1:0] box;
      int                             lo, hi, shape;
      shape = $urandom_range(9, 0);
      if (shape == 0)
         return pack_box(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
      if (shape == 1)
         return 48'({$urandom, $urandom});
      for (int d = 0; d < 3; d++) begin
         lo = $urandom_range(255, 0);
         hi = lo + $urandom_range(90, 0);
         box[16*d +: 8]     = 8'(lo);
         box[16*d + 8 +: 8] = (hi > 255) ? 8'd255 : 8'(hi);
      end
      if (shape == 2) begin
         // empty: hue low bound above hue high bound
         box[7:0]  = 8'($urandom_range(255, 1));
         box[15:8] = 8'($urandom_range(box[7:0] - 1, 0));
      end
      return box;
   endfunction

   // Value inside [lo, hi], favoring the bounds; anything when the range is empty.
   function automatic logic [7:0] pick_in(input logic [7:0] lo, input logic [7:0] hi);
      int roll;
      if (lo > hi)
         return 8'($urandom);
      roll = $urandom_range(7, 0);
      if (roll == 0)
         return lo;
      if (roll == 1)
         return hi;
      return 8'($urandom_range(hi, lo));
   endfunction

   // One well-formed frame aimed at a color box, with some stray pixels, or of random pixels only.
   task automatic random_frame(input int max_len);
      int                             len, focus;
      logic [hsvtl_pkg::BoxWidth-1:0] box;
      len   = $urandom_range(max_len, 1);
      focus = $urandom_range(ColorNone, ColorRed);
      for (int i = 0; i < len; i++) begin
         if (focus != ColorNone && $urandom_range(9, 0) != 0) begin
            box = box_plan[focus];
            send_pixel(pick_in(box[7:0], box[15:8]), pick_in(box[23:16], box[31:24]),
                       pick_in(box[39:32], box[47:40]), i == len - 1);
         end else begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == len - 1);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [hsvtl_pkg::BoxWidth-1:0] red_b, yellow_b, green_b;
      hsvtl_pkg::thresh_type          lim;
      int                             kind, phase_start;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset values: all boxes hold only the black pixel, thresholds 50/10/10/70.
      idle_odds = 6;
      send_pixel(8'd0,   8'd0,   8'd0,   1'b1);  // one-pixel frame hitting all three
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
      send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
      send_pixel(8'd0,   8'd0,   8'd0,   1'b1);
      wait_idle();

      // Directed: small thresholds so a handful of pixels decides each light.
      // Red and yellow share hue 20 to make an overlapping pixel.
      apply_settings(pack_box(8'd0,  8'd20, 8'd100, 8'd255, 8'd100, 8'd255),
                     pack_box(8'd20, 8'd40, 8'd100, 8'd255, 8'd100, 8'd255),
                     pack_box(8'd60, 8'd90, 8'd100, 8'd255, 8'd100, 8'd255),
                     limits(20'd2, 20'd2, 20'd1, 20'd3));
      // red wins, bounds touched at the low corner
      send_pixel(8'd5,  8'd200, 8'd200, 1'b0);
      send_pixel(8'd0,  8'd100, 8'd100, 1'b0);
      send_pixel(8'd19, 8'd255, 8'd255, 1'b1);
      // yellow wins
      send_pixel(8'd30, 8'd150, 8'd150, 1'b0);
      send_pixel(8'd40, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd21, 8'd120, 8'd130, 1'b1);
      // green count 2: above green_min, below arrow_max
      send_pixel(8'd60, 8'd100, 8'd100, 1'b0);
      send_pixel(8'd90, 8'd255, 8'd255, 1'b1);
      // green count 3 reaches arrow_max: full green
      send_pixel(8'd75, 8'd200, 8'd200, 1'b0);
      send_pixel(8'd75, 8'd200, 8'd200, 1'b0);
      send_pixel(8'd70, 8'd200, 8'd200, 1'b1);
      // overlap pixel alone in its frame: counts for red and yellow
      send_pixel(8'd20, 8'd200, 8'd200, 1'b1);
      // nothing inside any box, saturation just under the bound
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
      send_pixel(8'd200, 8'd99,  8'd100, 1'b1);
      // red dominant but yellow not minor: falls back to red
      send_pixel(8'd10, 8'd200, 8'd200, 1'b0);
      send_pixel(8'd10, 8'd200, 8'd200, 1'b0);
      send_pixel(8'd10, 8'd200, 8'd200, 1'b0);
      send_pixel(8'd30, 8'd200, 8'd200, 1'b0);
      send_pixel(8'd30, 8'd200, 8'd200, 1'b1);
      wait_idle();

      // Random phases, each with fresh boxes and thresholds; a few phases
      // push the thresholds to all-zero, all-ones or fully random values.
      for (int ph = 0; ph < 8; ph++) begin
         kind = (ph == 1) ? 1 : (ph == 3) ? 2 : (ph == 5) ? 3 : 0;
         case (kind)
            1:       lim = limits('0, '0, '0, '0);
            2:       lim = limits('1, '1, '1, '1);
            3:       lim = limits(20'($urandom), 20'($urandom), 20'($urandom),
                                  20'($urandom));
            default: lim = limits(20'($urandom_range(20, 0)), 20'($urandom_range(12, 0)),
                                  20'($urandom_range(15, 0)), 20'($urandom_range(40, 0)));
         endcase
         red_b    = random_box();
         yellow_b = random_box();
         green_b  = random_box();
         apply_settings(red_b, yellow_b, green_b, lim);
         idle_odds   = $urandom_range(40, 3);
         phase_start = pixels_queued;
         while (pixels_queued - phase_start < 200)
            random_frame(40);
         wait_idle();
      end

      // Last part, no idling: pixels and results back to back.
      idle_odds = 0;
      red_b    = random_box();
      yellow_b = random_box();
      green_b  = random_box();
      apply_settings(red_b, yellow_b, green_b, limits(20'd3, 20'd6, 20'd2, 20'd9));
      for (int f = 0; f < 10; f++)
         random_frame(20);
      wait_idle();

      if (!mismatch_seen)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #(50_000_000);
      $display("Test completed with failures");
      $finish;
   end

endmodule
